@@ rtl/spbs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spring preset bisection solver package
// Fixed-point constants, register indices and the hyperbolic CORDIC table.
// ----------------------------------------------------------------------------
package spbs_pkg;

  localparam int unsigned ITER_MAX_DEF = 32;

  // Register indices on the configuration port
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_FIRST    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_SECOND   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_FIRST   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHAPE_SECOND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_FIRST  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SECOND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_LIMIT   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_LIMIT   = 3'd7;

  // Reset values
  localparam logic [31:0] SHAPE_RST = 32'h0100_0000;  // 1.0 in Q8.24
  localparam logic [31:0] LOWER_RST = 32'hF600_0000;  // -10.0
  localparam logic [31:0] UPPER_RST = 32'h0A00_0000;  // +10.0

  // Search interval and angle width (Q8.24, |x| <= 10)
  localparam int unsigned AW = 29;
  localparam logic signed [AW-1:0] SEARCH_HI = 29'sd167772160;
  localparam logic signed [AW-1:0] SEARCH_LO = -29'sd167772160;

  // sinh argument clamp, 12.0 in Q8.24
  localparam logic [27:0] ARG_MAX_Q24 = 28'd201326592;

  // CORDIC constants, Q2.30
  localparam logic [31:0] INVK_Q30   = 32'd1296540104;
  localparam logic [31:0] LN2_Q30    = 32'd744261118;
  localparam logic [31:0] INVLN2_Q30 = 32'd1549082005;
  localparam logic [4:0]  CORDIC_LAST  = 5'd28;
  localparam logic [4:0]  CORDIC_REP_A = 5'd4;
  localparam logic [4:0]  CORDIC_REP_B = 5'd13;

  // atanh(2^-i) in Q.30
  function automatic logic [30:0] atanh_q30(input logic [4:0] i);
    logic [30:0] r;
    case (i)
      5'd1:    r = 31'd589812981;
      5'd2:    r = 31'd274247419;
      5'd3:    r = 31'd134923406;
      5'd4:    r = 31'd67196451;
      5'd5:    r = 31'd33565361;
      5'd6:    r = 31'd16778582;
      5'd7:    r = 31'd8388779;
      5'd8:    r = 31'd4194325;
      5'd9:    r = 31'd2097155;
      default: r = 31'(31'd1 << (5'd30 - i));
    endcase
    return r;
  endfunction

endpackage

@@ rtl/spring_preset_bisection_solver_core.sv @@
`timescale 1ns / 1ps
// Work per request: f is evaluated at both ends of the search interval and then at
//   up to ITER_MAX bisection midpoints.
// Throughput: one request at a time; each evaluation runs the 30-step hyperbolic
//   CORDIC twice and uses one shared 32x32 multiplier.
// Reset: asynchronous, active low; registers take their documented values,
//   sequencer idle, no result pending.
// ----------------------------------------------------------------------------
// Spring preset bisection solver core
// Finds the spring preset angle balancing a gravity torque and clamps the command.
// ----------------------------------------------------------------------------
module spring_preset_bisection_solver_core #(
  parameter int unsigned ITER_MAX = spbs_pkg::ITER_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [spbs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  // request
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [31:0]             gravity_torque_i,
  input  logic signed [31:0]             stiffness_angle_i,
  input  logic signed [31:0]             desired_angle_i,
  // result
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             command_angle_o,
  output logic signed [31:0]             preset_angle_o,
  output logic                           root_found_o
);
  import spbs_pkg::*;

  localparam int unsigned ITW = $clog2(ITER_MAX + 1);

  // Sequencer codes
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_U    = 4'd1;   // spring argument u = x -/+ s - off
  localparam logic [3:0] ST_MARG = 4'd2;   // a * |u|
  localparam logic [3:0] ST_ARG  = 4'd3;   // round and clamp to 12.0
  localparam logic [3:0] ST_MN   = 4'd4;   // m / ln2
  localparam logic [3:0] ST_N    = 4'd5;
  localparam logic [3:0] ST_MZ   = 4'd6;   // n * ln2
  localparam logic [3:0] ST_Z    = 4'd7;   // reduced argument, CORDIC seed
  localparam logic [3:0] ST_CORD = 4'd8;   // one micro-rotation per cycle
  localparam logic [3:0] ST_SINH = 4'd9;
  localparam logic [3:0] ST_MK   = 4'd10;  // k * sinh
  localparam logic [3:0] ST_TERM = 4'd11;
  localparam logic [3:0] ST_F    = 4'd12;  // f value and bisection decision
  localparam logic [3:0] ST_FIN  = 4'd13;  // preset, clamp, load result

  // Which point is being evaluated
  localparam logic [1:0] PH_LO  = 2'd0;
  localparam logic [1:0] PH_HI  = 2'd1;
  localparam logic [1:0] PH_MID = 2'd2;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] gain1_q, gain2_q, shape1_q, shape2_q;
  logic [31:0] off1_q, off2_q, lim_lo_q, lim_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain1_q  <= '0;
      gain2_q  <= '0;
      shape1_q <= SHAPE_RST;
      shape2_q <= SHAPE_RST;
      off1_q   <= '0;
      off2_q   <= '0;
      lim_lo_q <= LOWER_RST;
      lim_hi_q <= UPPER_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GAIN_FIRST:    gain1_q  <= cfg_data_i;
        REG_GAIN_SECOND:   gain2_q  <= cfg_data_i;
        REG_SHAPE_FIRST:   shape1_q <= cfg_data_i;
        REG_SHAPE_SECOND:  shape2_q <= cfg_data_i;
        REG_OFFSET_FIRST:  off1_q   <= cfg_data_i;
        REG_OFFSET_SECOND: off2_q   <= cfg_data_i;
        REG_LOWER_LIMIT:   lim_lo_q <= cfg_data_i;
        REG_UPPER_LIMIT:   lim_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  logic [3:0]               state_q, state_d;
  logic [1:0]               phase_q, phase_d;
  logic                     sel_q, sel_d;        // spring term 0 or 1
  logic signed [31:0]       tau_q, stf_q, qd_q;  // request payload
  logic signed [AW-1:0]     lo_q, lo_d, hi_q, hi_d, x_q, x_d;
  logic signed [31:0]       flo_q, flo_d, fhi_q, fhi_d;
  logic [ITW-1:0]           it_q, it_d;
  logic                     found_q, found_d;
  logic                     neg_q;
  logic [33:0]              mag_q;
  logic [63:0]              prod_q;
  logic [27:0]              m_q;
  logic [4:0]               n_q;
  logic signed [33:0]       cx_q, cy_q, cz_q;
  logic [4:0]               ci_q;
  logic                     crep_q;
  logic [30:0]              sh_q;
  logic signed [50:0]       acc_q;
  logic                     out_valid_q;
  logic signed [31:0]       cmd_q, pre_q;
  logic                     rf_q;

  assign in_ready_o      = (state_q == ST_IDLE);
  assign out_valid_o     = out_valid_q;
  assign command_angle_o = cmd_q;
  assign preset_angle_o  = pre_q;
  assign root_found_o    = rf_q;

  wire accept = in_valid_i && in_ready_o;

  // Operand selection for the current spring term
  wire [31:0] a_sel   = sel_q ? shape2_q : shape1_q;
  wire [31:0] k_sel   = sel_q ? gain2_q  : gain1_q;
  wire [31:0] off_sel = sel_q ? off2_q   : off1_q;

  // --------------------------------------------------------------------------
  // Shared 32x32 multiplier, product registered
  // --------------------------------------------------------------------------
  logic [31:0] mul_a, mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MARG: begin mul_a = a_sel;          mul_b = mag_q[31:0]; end
      ST_MN:   begin mul_a = {4'd0, m_q};    mul_b = INVLN2_Q30;  end
      ST_MZ:   begin mul_a = {27'd0, n_q};   mul_b = LN2_Q30;     end
      ST_MK:   begin mul_a = k_sel;          mul_b = {1'b0, sh_q}; end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // --------------------------------------------------------------------------
  // Per-state arithmetic
  // --------------------------------------------------------------------------
  // u = x - s - off1 or x + s - off2
  logic signed [33:0] u_val;
  always_comb begin
    if (sel_q) u_val = 34'(x_q) + 34'(stf_q) - 34'($signed(off_sel));
    else       u_val = 34'(x_q) - 34'(stf_q) - 34'($signed(off_sel));
  end

  // arg = min(12.0, round(a*|u|)); upper magnitude bits folded in by shifted adds
  logic [66:0] arg_full;
  logic [42:0] arg_q24;
  always_comb begin
    arg_full = {3'd0, prod_q} + 67'd8388608
             + (mag_q[32] ? {3'd0, a_sel, 32'd0} : 67'd0)
             + (mag_q[33] ? {2'd0, a_sel, 33'd0} : 67'd0);
    arg_q24  = arg_full[66:24];
  end

  wire [63:0] n_full = prod_q + 64'h0020_0000_0000_0000;   // + 2^53

  // reduced argument r = 64*m - n*ln2, small but the terms are wide
  wire [35:0] z_full = {2'd0, m_q, 6'd0} - prod_q[35:0];

  // CORDIC micro-rotation
  wire signed [33:0] c_dx = cx_q >>> ci_q;
  wire signed [33:0] c_dy = cy_q >>> ci_q;
  wire signed [33:0] c_t  = 34'($signed({1'b0, atanh_q30(ci_q)}));
  wire               c_rep = (ci_q == CORDIC_REP_A || ci_q == CORDIC_REP_B) && !crep_q;

  // sinh = ((e^r << n) - (e^-r >> n)) / 2 in Q16.16
  logic [63:0] ep, em;
  logic [64:0] sd;
  logic [48:0] sr;
  logic [30:0] sinh_v;
  always_comb begin
    ep = {30'd0, 34'(cx_q + cy_q)} << n_q;
    em = {30'd0, 34'(cx_q - cy_q)} >> n_q;
    sd = {1'b0, ep} - {1'b0, em};
    sr = sd[64] ? 49'd0 : 49'(({1'b0, sd[63:0]} + 65'd16384) >> 15);
    sinh_v = (sr > 49'h7FFF_FFFF) ? 31'h7FFF_FFFF : sr[30:0];
  end

  // k*sinh rounded, sign of u applied
  wire [64:0]        t_full = {1'b0, prod_q} + 65'd32768;
  wire signed [49:0] t_mag  = $signed({2'b00, t_full[63:16]});
  wire signed [49:0] t_val  = neg_q ? -t_mag : t_mag;

  // f = t1 + t2 - tau, saturated
  logic signed [51:0] f_full;
  logic signed [31:0] f_val;
  always_comb begin
    f_full = 52'(acc_q) - 52'(tau_q);
    if (f_full > 52'sd2147483647)       f_val = 32'sh7FFF_FFFF;
    else if (f_full < -52'sd2147483648) f_val = 32'sh8000_0000;
    else                                f_val = f_full[31:0];
  end

  // Bisection update on a midpoint value
  logic signed [AW-1:0] nlo, nhi;
  logic signed [31:0]   nflo, nfhi;
  logic signed [32:0]   fdiff;
  logic [32:0]          fdist;
  logic [ITW-1:0]       it_n;
  logic signed [AW:0]   lh_sum, nlh_sum;
  always_comb begin
    if (f_val[31] == flo_q[31]) begin
      nlo = x_q;  nhi = hi_q; nflo = f_val; nfhi = fhi_q;
    end else begin
      nlo = lo_q; nhi = x_q;  nflo = flo_q; nfhi = f_val;
    end
    fdiff   = 33'(nfhi) - 33'(nflo);
    fdist   = fdiff[32] ? 33'(-fdiff) : 33'(fdiff);
    it_n    = it_q + 1'b1;
    lh_sum  = (AW+1)'(lo_q) + (AW+1)'(hi_q);
    nlh_sum = (AW+1)'(nlo) + (AW+1)'(nhi);
  end

  // Preset and clamped command
  logic signed [AW-1:0] preset;
  logic signed [33:0]   cmd_raw, cmd_up, cmd_lo, cmd_c;
  logic signed [31:0]   cmd_sat;
  always_comb begin
    preset  = lh_sum[AW:1];
    cmd_raw = 34'(qd_q) + 34'(preset);
    cmd_up  = 34'($signed(lim_hi_q)) + 34'(preset);
    cmd_lo  = 34'($signed(lim_lo_q)) + 34'(preset);
    cmd_c   = cmd_raw;
    if (cmd_c > cmd_up) cmd_c = cmd_up;   // upper first, lower wins if crossed
    if (cmd_c < cmd_lo) cmd_c = cmd_lo;
    if (cmd_c > 34'sd2147483647)       cmd_sat = 32'sh7FFF_FFFF;
    else if (cmd_c < -34'sd2147483648) cmd_sat = 32'sh8000_0000;
    else                               cmd_sat = cmd_c[31:0];
  end

  wire fin_go = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    sel_d   = sel_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    x_d     = x_q;
    flo_d   = flo_q;
    fhi_d   = fhi_q;
    it_d    = it_q;
    found_d = found_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_U;
          phase_d = PH_LO;
          sel_d   = 1'b0;
          lo_d    = SEARCH_LO;
          hi_d    = SEARCH_HI;
          x_d     = SEARCH_LO;
          found_d = 1'b0;
          it_d    = '0;
        end
      end
      ST_U:    state_d = ST_MARG;
      ST_MARG: state_d = ST_ARG;
      ST_ARG:  state_d = ST_MN;
      ST_MN:   state_d = ST_N;
      ST_N:    state_d = ST_MZ;
      ST_MZ:   state_d = ST_Z;
      ST_Z:    state_d = ST_CORD;
      ST_CORD: begin
        if (ci_q == CORDIC_LAST && !c_rep) state_d = ST_SINH;
      end
      ST_SINH: state_d = ST_MK;
      ST_MK:   state_d = ST_TERM;
      ST_TERM: begin
        sel_d   = ~sel_q;
        state_d = sel_q ? ST_F : ST_U;
      end
      ST_F: begin
        state_d = ST_U;
        unique case (phase_q)
          PH_LO: begin
            flo_d   = f_val;
            x_d     = hi_q;
            phase_d = PH_HI;
          end
          PH_HI: begin
            fhi_d = f_val;
            if (flo_q != 0 && f_val != 0 && flo_q[31] != f_val[31]) begin
              found_d = 1'b1;
              x_d     = lh_sum[AW:1];
              phase_d = PH_MID;
            end else begin
              lo_d    = '0;           // no bracket: preset is zero
              hi_d    = '0;
              state_d = ST_FIN;
            end
          end
          default: begin
            it_d = it_n;
            if (f_val == 0) begin     // exact zero at the midpoint
              lo_d    = x_q;
              hi_d    = x_q;
              state_d = ST_FIN;
            end else begin
              lo_d  = nlo;
              hi_d  = nhi;
              flo_d = nflo;
              fhi_d = nfhi;
              x_d   = nlh_sum[AW:1];
              if (!(it_n < ITW'(ITER_MAX) && fdist > 33'd1)) state_d = ST_FIN;
            end
          end
        endcase
      end
      ST_FIN: begin
        if (fin_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_LO;
      sel_q       <= 1'b0;
      it_q        <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
      ci_q        <= 5'd1;
      crep_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      sel_q   <= sel_d;
      it_q    <= it_d;
      found_q <= found_d;
      if (fin_go)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (state_q == ST_Z) begin
        ci_q   <= 5'd1;
        crep_q <= 1'b0;
      end else if (state_q == ST_CORD) begin
        if (c_rep) begin
          crep_q <= 1'b1;
        end else begin
          crep_q <= 1'b0;
          ci_q   <= ci_q + 5'd1;
        end
      end
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    x_q   <= x_d;
    flo_q <= flo_d;
    fhi_q <= fhi_d;
    if (accept) begin
      tau_q <= gravity_torque_i;
      stf_q <= stiffness_angle_i;
      qd_q  <= desired_angle_i;
    end
    if (accept || state_q == ST_F) acc_q <= '0;
    else if (state_q == ST_TERM)   acc_q <= acc_q + 51'(t_val);
    if (state_q == ST_U) begin
      neg_q <= u_val[33];
      mag_q <= u_val[33] ? 34'(-u_val) : 34'(u_val);
    end
    if (state_q == ST_ARG)
      m_q <= (arg_q24 > 43'(ARG_MAX_Q24)) ? ARG_MAX_Q24 : arg_q24[27:0];
    if (state_q == ST_N) n_q <= n_full[58:54];
    if (state_q == ST_Z) begin
      cx_q <= $signed({2'b00, INVK_Q30});
      cy_q <= '0;
      cz_q <= $signed(z_full[33:0]);
    end else if (state_q == ST_CORD) begin
      if (!cz_q[33]) begin
        cx_q <= cx_q + c_dy;
        cy_q <= cy_q + c_dx;
        cz_q <= cz_q - c_t;
      end else begin
        cx_q <= cx_q - c_dy;
        cy_q <= cy_q - c_dx;
        cz_q <= cz_q + c_t;
      end
    end
    if (state_q == ST_SINH) sh_q <= sinh_v;
    if (fin_go) begin
      cmd_q <= cmd_sat;
      pre_q <= 32'(preset);
      rf_q  <= found_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE)
    else $error("request taken outside idle");

  a_cordic_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CORD |-> (ci_q >= 5'd1 && ci_q <= CORDIC_LAST))
    else $error("CORDIC index out of range");

  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    it_q <= ITW'(ITER_MAX))
    else $error("bisection ran past its step limit");

  a_no_root_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !root_found_o) |-> preset_angle_o == 0)
    else $error("preset non-zero without a bracket");

  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(command_angle_o) && out_valid_o)
    else $error("pending result changed");

endmodule
